### rtl/core/linear_blend_skinning_unit_macros.svh
// assertion macros for the linear blend skinning unit
// no dependencies; included by the top level, which provides clk and rst_n
`ifndef LINEAR_BLEND_SKINNING_UNIT_MACROS_SVH
`define LINEAR_BLEND_SKINNING_UNIT_MACROS_SVH

// same-cycle implication
`define LBS_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("lbs check failed");

// next-cycle implication
`define LBS_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("lbs check failed");

`endif

### rtl/core/lbs_pkg.sv
// shared types, constants and the micro-op table of the skinning unit
// no dependencies
package lbs_pkg;

  localparam int BONE_COUNT = 64;
  localparam int BONE_AW    = $clog2(BONE_COUNT);
  localparam int N_OPS      = 33;
  localparam int LAST_STEP  = N_OPS + 1;

  typedef enum logic [1:0] {OP_FRAME, OP_BIND, OP_SKIN} lbs_opcode_t;

  typedef struct packed {
    logic signed [31:0] x;
    logic signed [31:0] y;
    logic signed [31:0] z;
  } lbs_vec3_t;

  typedef struct packed {
    logic go;
    logic clr_sum;
  } lbs_dp_ctrl_t;

  typedef struct packed {
    logic done;
  } lbs_dp_stat_t;

  typedef enum logic [2:0] {A_QW, A_QX, A_QY, A_QZ, A_DX, A_DY, A_DZ, A_W} lbs_asel_t;
  typedef enum logic [2:0] {B_QW, B_QX, B_QY, B_QZ, B_M, B_PLO, B_PHI} lbs_bsel_t;
  typedef enum logic [1:0] {WB_NONE, WB_MAT, WB_POS, WB_SUM} lbs_wb_t;

  typedef struct packed {
    lbs_asel_t  a;
    lbs_bsel_t  b;
    logic       first;
    logic       neg;
    logic       hi;
    lbs_wb_t    wb;
    logic       diag;
    logic [3:0] idx;
  } lbs_op_t;

  // one product per step: rotation matrix, matrix times offset, weighting
  function automatic lbs_op_t lbs_op(input logic [5:0] k);
    lbs_op_t o;
    o = '{a: A_W, b: B_PLO, first: 1'b0, neg: 1'b0, hi: 1'b0,
          wb: WB_NONE, diag: 1'b0, idx: 4'd0};
    case (k)
      // m00 = 1 - 2(yy + zz)
      6'd0:  begin o.a = A_QY; o.b = B_QY; o.first = 1'b1; o.neg = 1'b1; end
      6'd1:  begin o.a = A_QZ; o.b = B_QZ; o.neg = 1'b1; o.wb = WB_MAT; o.diag = 1'b1;
                   o.idx = 4'd0; end
      // m01 = 2(xy - wz)
      6'd2:  begin o.a = A_QX; o.b = B_QY; o.first = 1'b1; end
      6'd3:  begin o.a = A_QW; o.b = B_QZ; o.neg = 1'b1; o.wb = WB_MAT; o.idx = 4'd1; end
      // m02 = 2(xz + wy)
      6'd4:  begin o.a = A_QX; o.b = B_QZ; o.first = 1'b1; end
      6'd5:  begin o.a = A_QW; o.b = B_QY; o.wb = WB_MAT; o.idx = 4'd2; end
      // m10 = 2(xy + wz)
      6'd6:  begin o.a = A_QX; o.b = B_QY; o.first = 1'b1; end
      6'd7:  begin o.a = A_QW; o.b = B_QZ; o.wb = WB_MAT; o.idx = 4'd3; end
      // m11 = 1 - 2(xx + zz)
      6'd8:  begin o.a = A_QX; o.b = B_QX; o.first = 1'b1; o.neg = 1'b1; end
      6'd9:  begin o.a = A_QZ; o.b = B_QZ; o.neg = 1'b1; o.wb = WB_MAT; o.diag = 1'b1;
                   o.idx = 4'd4; end
      // m12 = 2(yz - wx)
      6'd10: begin o.a = A_QY; o.b = B_QZ; o.first = 1'b1; end
      6'd11: begin o.a = A_QW; o.b = B_QX; o.neg = 1'b1; o.wb = WB_MAT; o.idx = 4'd5; end
      // m20 = 2(xz - wy)
      6'd12: begin o.a = A_QX; o.b = B_QZ; o.first = 1'b1; end
      6'd13: begin o.a = A_QW; o.b = B_QY; o.neg = 1'b1; o.wb = WB_MAT; o.idx = 4'd6; end
      // m21 = 2(yz + wx)
      6'd14: begin o.a = A_QY; o.b = B_QZ; o.first = 1'b1; end
      6'd15: begin o.a = A_QW; o.b = B_QX; o.wb = WB_MAT; o.idx = 4'd7; end
      // m22 = 1 - 2(xx + yy)
      6'd16: begin o.a = A_QX; o.b = B_QX; o.first = 1'b1; o.neg = 1'b1; end
      6'd17: begin o.a = A_QY; o.b = B_QY; o.neg = 1'b1; o.wb = WB_MAT; o.diag = 1'b1;
                   o.idx = 4'd8; end
      // rows of matrix times offset, plus current translation
      6'd18: begin o.a = A_DX; o.b = B_M; o.idx = 4'd0; o.first = 1'b1; end
      6'd19: begin o.a = A_DY; o.b = B_M; o.idx = 4'd1; end
      6'd20: begin o.a = A_DZ; o.b = B_M; o.idx = 4'd2; end
      6'd21: begin o.a = A_DX; o.b = B_M; o.idx = 4'd3; o.first = 1'b1; end
      6'd22: begin o.a = A_DY; o.b = B_M; o.idx = 4'd4; end
      6'd23: begin o.a = A_DZ; o.b = B_M; o.idx = 4'd5; end
      6'd24: begin o.a = A_DX; o.b = B_M; o.idx = 4'd6; o.first = 1'b1; end
      6'd25: begin o.a = A_DY; o.b = B_M; o.idx = 4'd7; end
      6'd26: begin o.a = A_DZ; o.b = B_M; o.idx = 4'd8; end
      // weighting, low and high halves of the position
      6'd27: begin o.b = B_PLO; o.idx = 4'd0; o.first = 1'b1; end
      6'd28: begin o.b = B_PHI; o.idx = 4'd0; o.hi = 1'b1; o.wb = WB_SUM; end
      6'd29: begin o.b = B_PLO; o.idx = 4'd1; o.first = 1'b1; end
      6'd30: begin o.b = B_PHI; o.idx = 4'd1; o.hi = 1'b1; o.wb = WB_SUM; end
      6'd31: begin o.b = B_PLO; o.idx = 4'd2; o.first = 1'b1; end
      6'd32: begin o.b = B_PHI; o.idx = 4'd2; o.hi = 1'b1; o.wb = WB_SUM; end
      default: o.first = 1'b0;
    endcase
    // row ends write the position lane
    if (k == 6'd20) begin o.wb = WB_POS; o.idx = 4'd2; end
    if (k == 6'd23) begin o.wb = WB_POS; o.idx = 4'd5; end
    if (k == 6'd26) begin o.wb = WB_POS; o.idx = 4'd8; end
    return o;
  endfunction

  // 48-bit accumulator to 32 bits with clip flag in bit 32
  function automatic logic [32:0] lbs_sat(input logic signed [47:0] s);
    logic hi_clip;
    logic lo_clip;
    hi_clip = !s[47] && (|s[46:31]);
    lo_clip = s[47] && !(&s[46:31]);
    if (hi_clip) return {1'b1, 32'h7fff_ffff};
    if (lo_clip) return {1'b1, 32'h8000_0000};
    return {1'b0, s[31:0]};
  endfunction

endpackage

### rtl/core/lbs_if.sv
// valid/ready channel interfaces for the skinning unit
// no dependencies
interface lbs_in_if;
  logic               valid;
  logic               ready;
  logic [1:0]         operation;
  logic [5:0]         bone_index;
  logic signed [31:0] vec_x;
  logic signed [31:0] vec_y;
  logic signed [31:0] vec_z;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic [16:0]        weight;
  logic               last_influence;

  modport source(output valid, operation, bone_index, vec_x, vec_y, vec_z,
                 quat_w, quat_x, quat_y, quat_z, weight, last_influence,
                 input ready);
  modport sink(input valid, operation, bone_index, vec_x, vec_y, vec_z,
               quat_w, quat_x, quat_y, quat_z, weight, last_influence,
               output ready);
endinterface

interface lbs_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] out_x;
  logic signed [31:0] out_y;
  logic signed [31:0] out_z;
  logic               saturated;

  modport source(output valid, out_x, out_y, out_z, saturated, input ready);
  modport sink(input valid, out_x, out_y, out_z, saturated, output ready);
endinterface

### rtl/core/lbs_tables.sv
// bone table memories: rotation, current and bind translation
// depends on lbs_pkg
module lbs_tables import lbs_pkg::*; (
  input  logic               clk,
  input  logic               we_frame,
  input  logic               we_bind,
  input  logic [BONE_AW-1:0] wr_addr,
  input  logic [63:0]        wr_rot,
  input  lbs_vec3_t          wr_vec,
  input  logic [BONE_AW-1:0] rd_addr,
  output logic [63:0]        rot_rd,
  output lbs_vec3_t          cur_rd,
  output lbs_vec3_t          bind_rd
);

  logic [63:0] rot_mem  [BONE_COUNT];
  lbs_vec3_t   cur_mem  [BONE_COUNT];
  lbs_vec3_t   bind_mem [BONE_COUNT];

  // write ports
  always_ff @(posedge clk) begin
    if (we_frame) begin
      rot_mem[wr_addr] <= wr_rot;
      cur_mem[wr_addr] <= wr_vec;
    end
    if (we_bind) begin
      bind_mem[wr_addr] <= wr_vec;
    end
  end

  // registered reads
  always_ff @(posedge clk) begin
    rot_rd  <= rot_mem[rd_addr];
    cur_rd  <= cur_mem[rd_addr];
    bind_rd <= bind_mem[rd_addr];
  end

endmodule

### rtl/core/lbs_datapath.sv
// shared multiplier, accumulator and step sequencer for one influence
// depends on lbs_pkg
module lbs_datapath import lbs_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  lbs_dp_ctrl_t       ctrl,
  output lbs_dp_stat_t       stat,
  input  logic [63:0]        rot,
  input  lbs_vec3_t          cur,
  input  lbs_vec3_t          bnd,
  input  lbs_vec3_t          vtx,
  input  logic [16:0]        weight,
  output logic signed [47:0] sum_x,
  output logic signed [47:0] sum_y,
  output logic signed [47:0] sum_z
);

  logic               run_r;
  logic [5:0]         step_r;
  logic signed [32:0] d_r   [3];
  logic signed [21:0] m_r   [9];
  logic signed [41:0] p_r   [3];
  logic signed [54:0] prod_r;
  logic signed [61:0] acc_r;
  logic signed [47:0] sum_r [3];

  lbs_op_t            op_m, op_a, op_w;
  logic signed [15:0] qw, qx, qy, qz;
  logic signed [31:0] tv [3];
  logic signed [32:0] mul_a;
  logic signed [21:0] mul_b;
  logic signed [61:0] prodx, acc_nxt, mat_v, rnd_v;
  logic               acc_en, wb_en;

  assign qw = rot[63:48];
  assign qx = rot[47:32];
  assign qy = rot[31:16];
  assign qz = rot[15:0];
  assign tv[0] = cur.x;
  assign tv[1] = cur.y;
  assign tv[2] = cur.z;

  // ops issued, accumulated and written back this cycle
  assign op_m   = lbs_op(step_r);
  assign op_a   = lbs_op(step_r - 6'd1);
  assign op_w   = lbs_op(step_r - 6'd2);
  assign acc_en = run_r && (step_r >= 6'd1) && (step_r <= 6'(N_OPS));
  assign wb_en  = run_r && (step_r >= 6'd2);
  assign stat.done = run_r && (step_r == 6'(LAST_STEP));

  // multiplier operand select
  always_comb begin
    case (op_m.a)
      A_QW:    mul_a = 33'(qw);
      A_QX:    mul_a = 33'(qx);
      A_QY:    mul_a = 33'(qy);
      A_QZ:    mul_a = 33'(qz);
      A_DX:    mul_a = d_r[0];
      A_DY:    mul_a = d_r[1];
      A_DZ:    mul_a = d_r[2];
      default: mul_a = $signed({16'd0, weight});
    endcase
    case (op_m.b)
      B_QW:    mul_b = 22'(qw);
      B_QX:    mul_b = 22'(qx);
      B_QY:    mul_b = 22'(qy);
      B_QZ:    mul_b = 22'(qz);
      B_M:     mul_b = m_r[op_m.idx];
      B_PLO:   mul_b = $signed({1'b0, p_r[op_m.idx[1:0]][20:0]});
      default: mul_b = 22'($signed(p_r[op_m.idx[1:0]][41:21]));
    endcase
  end

  // accumulate and writeback arithmetic
  always_comb begin
    prodx   = op_a.hi ? (62'(prod_r) <<< 21) : 62'(prod_r);
    acc_nxt = (op_a.first ? 62'sd0 : acc_r) + (op_a.neg ? -prodx : prodx);
    mat_v   = (op_w.diag ? (62'sd1 <<< 28) : 62'sd0) + (acc_r <<< 1) + 62'sd2048;
    rnd_v   = (acc_r + 62'sd32768) >>> 16;
  end

  // sequencer and datapath registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      step_r <= '0;
      for (int i = 0; i < 3; i++) sum_r[i] <= '0;
    end else begin
      if (ctrl.go) begin
        run_r  <= 1'b1;
        step_r <= '0;
      end else if (run_r) begin
        if (step_r == 6'(LAST_STEP)) begin
          run_r <= 1'b0;
        end
        step_r <= step_r + 6'd1;
      end
      if (ctrl.clr_sum) begin
        for (int i = 0; i < 3; i++) sum_r[i] <= '0;
      end else if (wb_en && op_w.wb == WB_SUM) begin
        sum_r[op_w.idx[1:0]] <= sum_r[op_w.idx[1:0]] + rnd_v[47:0];
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    if (acc_en) begin
      acc_r <= acc_nxt;
    end
    if (run_r && step_r == 6'd0) begin
      d_r[0] <= 33'(vtx.x) - 33'(bnd.x);
      d_r[1] <= 33'(vtx.y) - 33'(bnd.y);
      d_r[2] <= 33'(vtx.z) - 33'(bnd.z);
    end
    if (wb_en && op_w.wb == WB_MAT) begin
      m_r[op_w.idx] <= mat_v[33:12];
    end
    if (wb_en && op_w.wb == WB_POS) begin
      case (op_w.idx)
        4'd2:    p_r[0] <= rnd_v[41:0] + 42'(tv[0]);
        4'd5:    p_r[1] <= rnd_v[41:0] + 42'(tv[1]);
        default: p_r[2] <= rnd_v[41:0] + 42'(tv[2]);
      endcase
    end
  end

  assign sum_x = sum_r[0];
  assign sum_y = sum_r[1];
  assign sum_z = sum_r[2];

endmodule

### rtl/core/linear_blend_skinning_unit.sv
// top level of the linear blend skinning unit: control, tables, datapath
// depends on lbs_pkg, lbs_if, lbs_tables, lbs_datapath and the macros header
//
// channel   dir  word
// in_word   in   load frame / load bind / skin influence
// out_word  out  blended vertex position and clip flag
//
// loads write the bone tables when accepted; a skin influence runs its 33
// products through the one shared 33x22 multiplier.
// reset clears control and the blend sums; bone tables are not cleared.
// the last influence waits while a previous result is still held at the output.
`include "linear_blend_skinning_unit_macros.svh"

module linear_blend_skinning_unit import lbs_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  lbs_in_if.sink    in_word,
  lbs_out_if.source out_word
);

  typedef enum logic [1:0] {S_IDLE, S_READ, S_RUN, S_FIN} state_t;

  state_t             state_r;
  logic [BONE_AW-1:0] idx_r;
  lbs_vec3_t          vtx_r;
  logic [16:0]        weight_r;
  logic               last_r;
  logic               out_valid_r;
  logic signed [31:0] out_x_r, out_y_r, out_z_r;
  logic               sat_r;

  logic               in_acc;
  logic               out_free;
  logic               out_load;
  logic               sums_zero;
  lbs_vec3_t          in_vec;
  logic [63:0]        rot_rd;
  lbs_vec3_t          cur_rd, bind_rd;
  lbs_dp_ctrl_t       dp_ctrl;
  lbs_dp_stat_t       dp_stat;
  logic signed [47:0] sum_x, sum_y, sum_z;
  logic [32:0]        sx, sy, sz;

  assign in_word.ready = (state_r == S_IDLE);
  assign in_acc   = in_word.valid && in_word.ready;
  assign out_free = !out_valid_r || out_word.ready;
  assign out_load = (state_r == S_FIN) && last_r && out_free;
  assign in_vec   = '{x: in_word.vec_x, y: in_word.vec_y, z: in_word.vec_z};

  // bone tables
  lbs_tables u_tables (
    .clk      (clk),
    .we_frame (in_acc && in_word.operation == OP_FRAME),
    .we_bind  (in_acc && in_word.operation == OP_BIND),
    .wr_addr  (in_word.bone_index[BONE_AW-1:0]),
    .wr_rot   ({in_word.quat_w, in_word.quat_x, in_word.quat_y, in_word.quat_z}),
    .wr_vec   (in_vec),
    .rd_addr  (idx_r),
    .rot_rd   (rot_rd),
    .cur_rd   (cur_rd),
    .bind_rd  (bind_rd)
  );

  // datapath control
  assign dp_ctrl.go      = (state_r == S_READ);
  assign dp_ctrl.clr_sum = out_load;

  lbs_datapath u_dp (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (dp_ctrl),
    .stat   (dp_stat),
    .rot    (rot_rd),
    .cur    (cur_rd),
    .bnd    (bind_rd),
    .vtx    (vtx_r),
    .weight (weight_r),
    .sum_x  (sum_x),
    .sum_y  (sum_y),
    .sum_z  (sum_z)
  );

  // saturate the blended position
  assign sx = lbs_sat(sum_x);
  assign sy = lbs_sat(sum_y);
  assign sz = lbs_sat(sum_z);

  // state and output word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_word.ready) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_acc && in_word.operation == OP_SKIN) begin
            state_r <= S_READ;
          end
        end
        S_READ: state_r <= S_RUN;
        S_RUN: begin
          if (dp_stat.done) begin
            state_r <= S_FIN;
          end
        end
        S_FIN: begin
          if (!last_r || out_free) begin
            state_r <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  // item and result payload
  always_ff @(posedge clk) begin
    if (in_acc && in_word.operation == OP_SKIN) begin
      idx_r    <= in_word.bone_index[BONE_AW-1:0];
      vtx_r    <= in_vec;
      weight_r <= in_word.weight;
      last_r   <= in_word.last_influence;
    end
    if (out_load) begin
      out_x_r <= sx[31:0];
      out_y_r <= sy[31:0];
      out_z_r <= sz[31:0];
      sat_r   <= sx[32] | sy[32] | sz[32];
    end
  end

  assign out_word.valid     = out_valid_r;
  assign out_word.out_x     = out_x_r;
  assign out_word.out_y     = out_y_r;
  assign out_word.out_z     = out_z_r;
  assign out_word.saturated = sat_r;

  // checks
  assign sums_zero = (sum_x == 48'sd0) && (sum_y == 48'sd0) && (sum_z == 48'sd0);
  `LBS_ASSERT_IMP(a_done_in_run, dp_stat.done, state_r == S_RUN)
  `LBS_ASSERT_NXT(a_out_from_fin, !out_valid_r && (state_r != S_FIN), !out_valid_r)
  `LBS_ASSERT_NXT(a_sum_cleared, dp_ctrl.clr_sum, sums_zero)

endmodule
